// File: rtl/fpw_pkg.sv
package fpw_pkg;

  localparam int MEM_ENTRIES_DEF = 256;
  localparam int ADDR_W = 64;
  localparam int PHYS_W = 52;
  localparam int VA_W = 48;
  localparam int IDX_BITS = 9;
  localparam int OFS_BITS = 12;
  localparam int LVL0_HI = 47;
  localparam int LVL1_HI = 38;
  localparam int LVL2_HI = 29;
  localparam int LVL3_HI = 20;
  localparam int FRAME_HI = 51;
  localparam int ENTRY_SHIFT = 3;
  localparam logic [1:0] LAST_LVL = 2'd3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XLATE = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic              fault;
    logic [PHYS_W-1:0] phys;
  } res_t;

  function automatic logic [IDX_BITS-1:0] level_index(input logic [VA_W-1:0] va,
                                                      input logic [1:0] lvl);
    logic [IDX_BITS-1:0] idx;
    case (lvl)
      2'd0: idx = va[LVL0_HI -: IDX_BITS];
      2'd1: idx = va[LVL1_HI -: IDX_BITS];
      2'd2: idx = va[LVL2_HI -: IDX_BITS];
      2'd3: idx = va[LVL3_HI -: IDX_BITS];
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

// File: rtl/fpw_front.sv
module fpw_front import fpw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              req_type,
  input  logic [ADDR_W-1:0] word_addr,
  input  logic [ADDR_W-1:0] word_value,
  input  logic [ADDR_W-1:0] virt_addr,
  output logic              q_empty,
  input  logic              q_pop,
  output cmd_t              q_cmd
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  cmd_t              cmd_in;
  logic              do_push;
  logic              do_pop;

  // classify: loads carry the word address, translations the virtual address
  always_comb begin
    cmd_in.op    = req_type ? OP_XLATE : OP_LOAD;
    cmd_in.addr  = req_type ? virt_addr : word_addr;
    cmd_in.value = word_value;
  end

  assign full    = (cnt == QCNT_W'(QDEPTH));
  assign q_empty = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && !q_empty;
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// File: rtl/fpw_walk.sv
module fpw_walk import fpw_pkg::*; #(
  parameter int MEM_ENTRIES = MEM_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  output logic              q_pop,
  input  cmd_t              q_cmd,
  input  logic [ADDR_W-1:0] root,
  input  logic              res_full,
  output logic              res_push,
  output res_t              res
);

  localparam int IDX_W = (MEM_ENTRIES > 1) ? $clog2(MEM_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MEM_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MEM_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADDR = 4'b0010,
    S_SCAN = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  scan_i;
  logic              rd_pend;
  logic [1:0]        lvl;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] ea;
  logic [VA_W-1:0]   va;
  res_t              res_q;

  logic [ADDR_W-1:0] mem_a [MEM_ENTRIES];
  logic [ADDR_W-1:0] mem_v [MEM_ENTRIES];
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] rd_val;

  logic              hit;
  logic              absent;
  logic              rd_en;
  logic              wr_en;
  logic [ADDR_W-1:0] entry;

  assign hit    = rd_pend && (rd_addr == ea);
  assign absent = !rd_pend && (scan_i == count);
  assign entry  = hit ? rd_val : '0;
  assign rd_en  = (state == S_SCAN) && !hit && (scan_i != count);
  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign wr_en  = q_pop && (q_cmd.op == OP_LOAD) && (count != CNT_MAX);

  assign res_push = (state == S_PUSH) && !res_full;
  assign res      = res_q;

  // word store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[count[IDX_W-1:0]] <= q_cmd.addr;
      mem_v[count[IDX_W-1:0]] <= q_cmd.value;
    end
    if (rd_en) begin
      rd_addr <= mem_a[scan_i[IDX_W-1:0]];
      rd_val  <= mem_v[scan_i[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_cmd.op == OP_LOAD) begin
              if (wr_en) begin
                count <= count + 1'b1;
              end
            end else begin
              va    <= q_cmd.addr[VA_W-1:0];
              base  <= root;
              lvl   <= '0;
              state <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          ea      <= base + {{(ADDR_W-IDX_BITS-ENTRY_SHIFT){1'b0}},
                             level_index(va, lvl), {ENTRY_SHIFT{1'b0}}};
          scan_i  <= '0;
          rd_pend <= 1'b0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          rd_pend <= rd_en;
          if (rd_en) begin
            scan_i <= scan_i + 1'b1;
          end
          if (hit || absent) begin
            if (!entry[0]) begin
              res_q.fault <= 1'b1;
              res_q.phys  <= '0;
              state       <= S_PUSH;
            end else if (lvl == LAST_LVL) begin
              res_q.fault <= 1'b0;
              res_q.phys  <= {entry[FRAME_HI:OFS_BITS], va[OFS_BITS-1:0]};
              state       <= S_PUSH;
            end else begin
              base  <= {{(ADDR_W-FRAME_HI-1){1'b0}}, entry[FRAME_HI:OFS_BITS],
                        {OFS_BITS{1'b0}}};
              lvl   <= lvl + 1'b1;
              state <= S_ADDR;
            end
          end
        end
        S_PUSH: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/fpw_out.sv
module fpw_out import fpw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_push,
  input  res_t              res,
  output logic              res_full,
  output logic              empty,
  input  logic              pop,
  output logic              fault,
  output logic [PHYS_W-1:0] paddr
);

  res_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              do_push;
  logic              do_pop;

  assign res_full  = (cnt == QCNT_W'(QDEPTH));
  assign empty     = (cnt == '0);
  assign do_push   = res_push && !res_full;
  assign do_pop    = pop && !empty;
  assign fault     = slots[rd_ptr].fault;
  assign paddr     = slots[rd_ptr].phys;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// File: rtl/four_level_page_walker.sv
// four-level page table walker over a small loaded word store
// input channel: push/full with req_type, word_addr, word_value, virt_addr;
//   a request is taken at a clock edge with push high and full low
// load requests (req_type 0) append one address/value pair and give no result;
//   loads beyond MEM_ENTRIES pairs are dropped
// translate requests (req_type 1) give one result: fault, paddr
// result channel: empty/pop; the oldest result sits on fault/paddr while
//   empty is low and leaves at an edge with pop high and empty low
// root_table_addr is written at an edge with root_table_addr_we high; the user
//   must write it only while no request is in flight; the block does not enforce it
// a two-entry request queue feeds the walker, a two-entry result queue drains it
// load: written to the store in S_IDLE as the request is taken; translate: per
//   level S_ADDR forms the entry address, then S_SCAN reads the word store,
//   which has a single read port, slot by slot from slot 0 up to the matching
//   word, or to the fill count N when absent; S_IDLE takes each request and
//   S_PUSH posts the result, waiting while the result queue is full
// the walker takes no new request until the last result is posted
// reset empties both queues, clears the fill count and the root register
// a stalled result side fills the result queue, then the walker, then full
module four_level_page_walker import fpw_pkg::*; #(
  parameter int MEM_ENTRIES = MEM_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              req_type,
  input  logic [ADDR_W-1:0] word_addr,
  input  logic [ADDR_W-1:0] word_value,
  input  logic [ADDR_W-1:0] virt_addr,
  output logic              empty,
  input  logic              pop,
  output logic              fault,
  output logic [PHYS_W-1:0] paddr,
  input  logic              root_table_addr_we,
  input  logic [ADDR_W-1:0] root_table_addr
);

  logic [ADDR_W-1:0] root;
  logic              q_empty;
  logic              q_pop;
  cmd_t              q_cmd;
  logic              res_full;
  logic              res_push;
  res_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (root_table_addr_we) begin
      root <= root_table_addr;
    end
  end

  fpw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .word_addr  (word_addr),
    .word_value (word_value),
    .virt_addr  (virt_addr),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd)
  );

  fpw_walk #(
    .MEM_ENTRIES (MEM_ENTRIES)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd),
    .root     (root),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  fpw_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full),
    .empty     (empty),
    .pop       (pop),
    .fault     (fault),
    .paddr     (paddr)
  );

endmodule

// File: rtl/fpw_checker.sv
module fpw_checker import fpw_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic              fault,
  input logic [PHYS_W-1:0] paddr
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("request queue full after reset");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && fault) |-> (paddr == '0))
    else $error("faulted result carries an address");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(fault) && $stable(paddr)))
    else $error("waiting result changed");

endmodule

bind four_level_page_walker fpw_checker u_fpw_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .fault     (fault),
  .paddr     (paddr)
);
